FILE: hw/rtl/fsc_pkg.sv
`timescale 1ns / 1ps

package fsc_pkg;

	typedef enum logic [2:0] {
		OP_GEAR_UP   = 3'd0,
		OP_GEAR_DOWN = 3'd1,
		OP_ENCODER   = 3'd2,
		OP_FAN       = 3'd3,
		OP_SWING     = 3'd4,
		OP_TEMP      = 3'd5,
		OP_SECOND    = 3'd6,
		OP_SPEED     = 3'd7
	} op_t;

	localparam logic [2:0] REG_MODE       = 3'd0;
	localparam logic [2:0] REG_MAX_GEAR   = 3'd1;
	localparam logic [2:0] REG_MIN_FREQ   = 3'd2;
	localparam logic [2:0] REG_MAX_FREQ   = 3'd3;
	localparam logic [2:0] REG_LOW_TEMP   = 3'd4;
	localparam logic [2:0] REG_HIGH_TEMP  = 3'd5;
	localparam logic [2:0] REG_SLEEP      = 3'd6;
	localparam logic [2:0] REG_POWER_OFF  = 3'd7;

	localparam logic [1:0]  MODE_RESET      = 2'd0;
	localparam logic [7:0]  MAX_GEAR_RESET  = 8'd10;
	localparam logic [15:0] MIN_FREQ_RESET  = 16'd0;
	localparam logic [15:0] MAX_FREQ_RESET  = 16'd25000;
	localparam logic [7:0]  LOW_TEMP_RESET  = 8'd25;
	localparam logic [7:0]  HIGH_TEMP_RESET = 8'd35;
	localparam logic [15:0] SLEEP_RESET     = 16'd30;
	localparam logic [15:0] POWER_OFF_RESET = 16'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVENT,
		ST_AUTO_MUL,
		ST_AUTO_DIV,
		ST_AUTO_WAIT,
		ST_AUTO_SET,
		ST_CLAMP,
		ST_OUT_MUL,
		ST_OUT_DIV,
		ST_OUT_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply_event;
		logic mul_auto;
		logic set_auto;
		logic clamp;
		logic mul_out;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_auto_div;
		logic need_out_div;
	} status_t;

endpackage

FILE: hw/rtl/fan_speed_controller.sv
`timescale 1ns / 1ps

// Event-driven fan controller. Each request carries one event (gear up/down, encoder activity,
// fan or swing button, temperature sample, one-second tick, speed tick) and yields exactly one
// result with gear, drive duty, drive frequency, status bits and event notices. Requests are
// handled one at a time by a state machine around a shared bit-serial divider that produces one
// quotient bit per cycle over a PROD_W-bit dividend, PROD_W = 8 + max(16, bits of
// DUTY_FULL_SCALE), which is 24 at the default. A speed tick in auto mode with the temperature
// strictly between the limits takes one more division, and with max gear zero the output
// division is skipped. The next request is taken as soon as the result is written to the
// output register, even while that result is still stalled.
// Configuration is written through a plain write port; the user must write it only while no
// request is in flight, which the block itself does not enforce.
module fan_speed_controller
	import fsc_pkg::*;
#(
	parameter int DUTY_FULL_SCALE = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        operation,
	input  logic signed [7:0] temperature_sample,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        gear_level,
	output logic [7:0]        pwm_duty,
	output logic [15:0]       pwm_frequency,
	output logic              fan_on,
	output logic              swing_on,
	output logic              backlight_on,
	output logic              gear_notice,
	output logic              power_notice,
	output logic              swing_notice,
	output logic              sleep_notice,
	output logic              wake_notice,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int FULL_W = $clog2(DUTY_FULL_SCALE + 1);
	localparam int PROD_W = 8 + ((FULL_W > 16) ? FULL_W : 16);

	cmd_t              cmd;
	status_t           status;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [PROD_W-1:0] div_dividend;
	logic [7:0]        div_divisor;
	logic [PROD_W-1:0] div_quotient;

	fsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.div_start (div_start),
		.div_busy  (div_busy),
		.div_done  (div_done)
	);

	fsc_divider #(
		.DIVIDEND_W (PROD_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	fsc_datapath #(
		.DUTY_FULL_SCALE (DUTY_FULL_SCALE),
		.PROD_W          (PROD_W)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.operation          (operation),
		.temperature_sample (temperature_sample),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.div_dividend       (div_dividend),
		.div_divisor        (div_divisor),
		.div_quotient       (div_quotient),
		.gear_level         (gear_level),
		.pwm_duty           (pwm_duty),
		.pwm_frequency      (pwm_frequency),
		.fan_on             (fan_on),
		.swing_on           (swing_on),
		.backlight_on       (backlight_on),
		.gear_notice        (gear_notice),
		.power_notice       (power_notice),
		.swing_notice       (swing_notice),
		.sleep_notice       (sleep_notice),
		.wake_notice        (wake_notice)
	);

endmodule

FILE: hw/rtl/fsc_divider.sv
`timescale 1ns / 1ps

module fsc_divider #(
	parameter int DIVIDEND_W = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [7:0]            divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [7:0]            rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [7:0]            dsr_q;
	logic [8:0]            trial;
	logic [8:0]            diff;
	logic                  ge;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[7:0] : trial[7:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/fsc_datapath.sv
`timescale 1ns / 1ps

module fsc_datapath
	import fsc_pkg::*;
#(
	parameter int DUTY_FULL_SCALE = 256,
	parameter int PROD_W          = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [2:0]         operation,
	input  logic signed [7:0]  temperature_sample,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic [PROD_W-1:0]  div_dividend,
	output logic [7:0]         div_divisor,
	input  logic [PROD_W-1:0]  div_quotient,
	output logic [7:0]         gear_level,
	output logic [7:0]         pwm_duty,
	output logic [15:0]        pwm_frequency,
	output logic               fan_on,
	output logic               swing_on,
	output logic               backlight_on,
	output logic               gear_notice,
	output logic               power_notice,
	output logic               swing_notice,
	output logic               sleep_notice,
	output logic               wake_notice
);

	localparam int               HALF   = DUTY_FULL_SCALE / 2;
	localparam logic [7:0]       HALF8  = 8'(HALF);
	localparam logic [PROD_W-1:0] FULL_P = PROD_W'(DUTY_FULL_SCALE);
	localparam logic [PROD_W-1:0] CAP_P  = PROD_W'(DUTY_FULL_SCALE - 1);

	// configuration
	logic [1:0]        mode_q;
	logic [7:0]        max_gear_q;
	logic [15:0]       min_freq_q;
	logic [15:0]       max_freq_q;
	logic signed [7:0] low_temp_q;
	logic signed [7:0] high_temp_q;
	logic [15:0]       sleep_sec_q;
	logic [15:0]       power_off_sec_q;

	// controller state
	logic [7:0]        gear_q;
	logic signed [7:0] temp_q;
	logic              fan_q;
	logic              swing_q;
	logic [15:0]       sleep_q;
	logic [15:0]       power_off_q;
	logic              gn_q;
	logic              pn_q;
	logic              sn_q;
	logic              sln_q;
	logic              wn_q;

	// request and arithmetic
	op_t               op_q;
	logic signed [7:0] sample_q;
	logic [PROD_W-1:0] prod_q;
	logic [7:0]        dsr_q;

	logic              auto_ok;
	logic              t_ge_hi;
	logic              t_le_lo;
	logic signed [8:0] t_minus_lo;
	logic signed [8:0] hi_minus_lo;
	logic              freq_neg;
	logic [15:0]       freq_mag;
	logic [15:0]       q16;
	logic [7:0]        duty_d;
	logic [15:0]       freq_d;
	logic [PROD_W-1:0] duty_q;

	assign auto_ok     = mode_q[1] && fan_q && (low_temp_q <= high_temp_q);
	assign t_ge_hi     = temp_q >= high_temp_q;
	assign t_le_lo     = temp_q <= low_temp_q;
	assign t_minus_lo  = {temp_q[7], temp_q} - {low_temp_q[7], low_temp_q};
	assign hi_minus_lo = {high_temp_q[7], high_temp_q} - {low_temp_q[7], low_temp_q};
	assign freq_neg    = max_freq_q < min_freq_q;
	assign freq_mag    = freq_neg ? (min_freq_q - max_freq_q) : (max_freq_q - min_freq_q);
	assign q16         = div_quotient[15:0];

	assign status.need_auto_div = (op_q == OP_SPEED) && auto_ok && !t_ge_hi && !t_le_lo;
	assign status.need_out_div  = max_gear_q != 8'd0;

	assign div_dividend = prod_q;
	assign div_divisor  = dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_RESET;
			max_gear_q      <= MAX_GEAR_RESET;
			min_freq_q      <= MIN_FREQ_RESET;
			max_freq_q      <= MAX_FREQ_RESET;
			low_temp_q      <= LOW_TEMP_RESET;
			high_temp_q     <= HIGH_TEMP_RESET;
			sleep_sec_q     <= SLEEP_RESET;
			power_off_sec_q <= POWER_OFF_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MODE:      mode_q          <= cfg_data[1:0];
				REG_MAX_GEAR:  max_gear_q      <= cfg_data[7:0];
				REG_MIN_FREQ:  min_freq_q      <= cfg_data;
				REG_MAX_FREQ:  max_freq_q      <= cfg_data;
				REG_LOW_TEMP:  low_temp_q      <= cfg_data[7:0];
				REG_HIGH_TEMP: high_temp_q     <= cfg_data[7:0];
				REG_SLEEP:     sleep_sec_q     <= cfg_data;
				REG_POWER_OFF: power_off_sec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q      <= '0;
			temp_q      <= '0;
			fan_q       <= 1'b0;
			swing_q     <= 1'b0;
			sleep_q     <= SLEEP_RESET;
			power_off_q <= POWER_OFF_RESET;
			gn_q        <= 1'b0;
			pn_q        <= 1'b0;
			sn_q        <= 1'b0;
			sln_q       <= 1'b0;
			wn_q        <= 1'b0;
		end else if (cmd.capture) begin
			gn_q  <= 1'b0;
			pn_q  <= 1'b0;
			sn_q  <= 1'b0;
			sln_q <= 1'b0;
			wn_q  <= 1'b0;
		end else if (cmd.apply_event) begin
			case (op_q)
				OP_GEAR_UP: begin
					gear_q <= (gear_q < max_gear_q) ? gear_q + 8'd1 : max_gear_q;
					gn_q   <= 1'b1;
				end
				OP_GEAR_DOWN: begin
					if (gear_q != 8'd0)
						gear_q <= gear_q - 8'd1;
					gn_q <= 1'b1;
				end
				OP_ENCODER: begin
					wn_q    <= sleep_q == 16'd0;
					sleep_q <= sleep_sec_q;
				end
				OP_FAN: begin
					wn_q    <= sleep_q == 16'd0;
					sleep_q <= sleep_sec_q;
					fan_q   <= !fan_q;
					pn_q    <= 1'b1;
				end
				OP_SWING: begin
					wn_q    <= sleep_q == 16'd0;
					sleep_q <= sleep_sec_q;
					swing_q <= !swing_q;
					sn_q    <= 1'b1;
				end
				OP_TEMP: begin
					if (sample_q != temp_q) begin
						temp_q <= sample_q;
						gn_q   <= 1'b1;
					end
				end
				OP_SECOND: begin
					if (sleep_q != 16'd0) begin
						sleep_q <= sleep_q - 16'd1;
						sln_q   <= sleep_q == 16'd1;
					end
					if (!fan_q) begin
						power_off_q <= power_off_sec_q;
					end else if (power_off_q != 16'd0) begin
						power_off_q <= power_off_q - 16'd1;
						if (power_off_q == 16'd1) begin
							fan_q <= 1'b0;
							pn_q  <= 1'b1;
						end
					end
				end
				OP_SPEED: begin
					// the in-between case goes through the divider
					if (auto_ok) begin
						if (t_ge_hi) begin
							if (gear_q != max_gear_q) begin
								gear_q <= max_gear_q;
								gn_q   <= 1'b1;
							end
						end else if (t_le_lo) begin
							if (gear_q != 8'd0) begin
								gear_q <= 8'd0;
								gn_q   <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end else if (cmd.set_auto) begin
			if (div_quotient[7:0] != gear_q) begin
				gear_q <= div_quotient[7:0];
				gn_q   <= 1'b1;
			end
		end else if (cmd.clamp) begin
			if (gear_q > max_gear_q) begin
				gear_q <= max_gear_q;
				gn_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op_t'(operation);
			sample_q <= temperature_sample;
		end
		if (cmd.mul_auto) begin
			prod_q <= PROD_W'(t_minus_lo[7:0]) * PROD_W'(max_gear_q);
			dsr_q  <= hi_minus_lo[7:0];
		end else if (cmd.mul_out) begin
			prod_q <= mode_q[0] ? PROD_W'(gear_q) * PROD_W'(freq_mag)
			                    : PROD_W'(gear_q) * FULL_P;
			dsr_q  <= max_gear_q;
		end
	end

	assign duty_q = (div_quotient >= CAP_P) ? CAP_P : div_quotient;

	always_comb begin
		if (mode_q[0]) begin
			duty_d = (gear_q == 8'd0) ? 8'd0 : HALF8;
			if (max_gear_q == 8'd0)
				freq_d = min_freq_q;
			else
				freq_d = freq_neg ? (min_freq_q - q16) : (min_freq_q + q16);
		end else begin
			duty_d = (max_gear_q == 8'd0) ? 8'd0 : duty_q[7:0];
			freq_d = max_freq_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			gear_level    <= gear_q;
			pwm_duty      <= duty_d;
			pwm_frequency <= freq_d;
			fan_on        <= fan_q;
			swing_on      <= swing_q;
			backlight_on  <= sleep_q != 16'd0;
			gear_notice   <= gn_q;
			power_notice  <= pn_q;
			swing_notice  <= sn_q;
			sleep_notice  <= sln_q;
			wake_notice   <= wn_q;
		end
	end

endmodule

FILE: hw/rtl/fsc_ctrl.sv
`timescale 1ns / 1ps

module fsc_ctrl
	import fsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd,
	output logic    div_start,
	input  logic    div_busy,
	input  logic    div_done
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		div_start = 1'b0;
		in_stall  = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVENT;
				end
			end
			ST_EVENT: begin
				cmd.apply_event = 1'b1;
				state_d         = status.need_auto_div ? ST_AUTO_MUL : ST_CLAMP;
			end
			ST_AUTO_MUL: begin
				cmd.mul_auto = 1'b1;
				state_d      = ST_AUTO_DIV;
			end
			ST_AUTO_DIV: begin
				div_start = 1'b1;
				state_d   = ST_AUTO_WAIT;
			end
			ST_AUTO_WAIT: begin
				if (div_done)
					state_d = ST_AUTO_SET;
			end
			ST_AUTO_SET: begin
				cmd.set_auto = 1'b1;
				state_d      = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = status.need_out_div ? ST_OUT_MUL : ST_RESULT;
			end
			ST_OUT_MUL: begin
				cmd.mul_out = 1'b1;
				state_d     = ST_OUT_DIV;
			end
			ST_OUT_DIV: begin
				div_start = 1'b1;
				state_d   = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (div_done)
					state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_accept_event: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EVENT))
		else $error("accepted request not followed by event step");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_RESULT))
		else $error("result raised outside result step");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_AUTO_WAIT || state_q == ST_OUT_WAIT))
		else $error("divider finished while nobody waits");

endmodule

FILE: verif/fan_speed_controller_tb.sv
`timescale 1ns / 1ps

module fan_speed_controller_tb;
	import fsc_pkg::*;

	localparam int DUTY_SCALE = 256;

	typedef struct packed {
		logic [7:0]  gear_level;
		logic [7:0]  pwm_duty;
		logic [15:0] pwm_frequency;
		logic        fan_on;
		logic        swing_on;
		logic        backlight_on;
		logic        gear_notice;
		logic        power_notice;
		logic        swing_notice;
		logic        sleep_notice;
		logic        wake_notice;
	} fan_status_t;

	typedef struct packed {
		logic              is_write;
		logic              has_fixed;
		logic [2:0]        reg_index;
		logic [15:0]       reg_value;
		op_t               op;
		logic signed [7:0] sample;
		fan_status_t       fixed;
	} script_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        operation = '0;
	logic signed [7:0] temperature_sample = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        gear_level;
	logic [7:0]        pwm_duty;
	logic [15:0]       pwm_frequency;
	logic              fan_on;
	logic              swing_on;
	logic              backlight_on;
	logic              gear_notice;
	logic              power_notice;
	logic              swing_notice;
	logic              sleep_notice;
	logic              wake_notice;
	logic              cfg_write = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;

	// register copies
	logic [1:0]        mode_r;
	logic [7:0]        max_gear_r;
	logic [15:0]       min_freq_r;
	logic [15:0]       max_freq_r;
	logic signed [7:0] low_r;
	logic signed [7:0] high_r;
	logic [15:0]       sleep_r;
	logic [15:0]       power_off_r;

	// controller state copies
	logic [7:0]        gear_now;
	logic signed [7:0] temp_now;
	logic              fan_now;
	logic              swing_now;
	logic [15:0]       sleep_left;
	logic [15:0]       power_left;

	fan_status_t expected_status[$];
	script_row_t script[$];
	int          error_count = 0;
	logic        calm_source = 1'b0;
	logic        calm_sink = 1'b0;

	fan_speed_controller #(
		.DUTY_FULL_SCALE(DUTY_SCALE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.temperature_sample(temperature_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gear_level(gear_level),
		.pwm_duty(pwm_duty),
		.pwm_frequency(pwm_frequency),
		.fan_on(fan_on),
		.swing_on(swing_on),
		.backlight_on(backlight_on),
		.gear_notice(gear_notice),
		.power_notice(power_notice),
		.swing_notice(swing_notice),
		.sleep_notice(sleep_notice),
		.wake_notice(wake_notice),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("%0t: timeout", $time);
		$display("Test completed with failures");
		$finish;
	end

	function automatic fan_status_t step_controller(input op_t op,
			input logic signed [7:0] sample);
		fan_status_t r;
		int t, lo, hi, mg, gv, d, minf, maxf, diff, mag, q, f;
		r = '0;
		case (op)
			OP_GEAR_UP: begin
				if (gear_now < max_gear_r)
					gear_now = gear_now + 8'd1;
				else
					gear_now = max_gear_r;
				r.gear_notice = 1'b1;
			end
			OP_GEAR_DOWN: begin
				if (gear_now > 8'd0)
					gear_now = gear_now - 8'd1;
				r.gear_notice = 1'b1;
			end
			OP_ENCODER, OP_FAN, OP_SWING: begin
				r.wake_notice = (sleep_left == 16'd0);
				sleep_left = sleep_r;
				if (op == OP_FAN) begin
					fan_now = ~fan_now;
					r.power_notice = 1'b1;
				end
				if (op == OP_SWING) begin
					swing_now = ~swing_now;
					r.swing_notice = 1'b1;
				end
			end
			OP_TEMP: begin
				if (sample != temp_now) begin
					temp_now = sample;
					r.gear_notice = 1'b1;
				end
			end
			OP_SECOND: begin
				if (sleep_left != 16'd0) begin
					sleep_left = sleep_left - 16'd1;
					r.sleep_notice = (sleep_left == 16'd0);
				end
				if (!fan_now) begin
					power_left = power_off_r;
				end else if (power_left != 16'd0) begin
					power_left = power_left - 16'd1;
					if (power_left == 16'd0) begin
						fan_now = 1'b0;
						r.power_notice = 1'b1;
					end
				end
			end
			default: begin
				if (mode_r[1] && fan_now && low_r <= high_r) begin
					t = temp_now;
					lo = low_r;
					hi = high_r;
					mg = max_gear_r;
					if (t >= hi)
						q = mg;
					else if (t <= lo)
						q = 0;
					else
						q = (t - lo) * mg / (hi - lo);
					if (8'(q) != gear_now) begin
						gear_now = 8'(q);
						r.gear_notice = 1'b1;
					end
				end
			end
		endcase

		// max gear lowered under the current gear
		if (gear_now > max_gear_r) begin
			gear_now = max_gear_r;
			r.gear_notice = 1'b1;
		end

		gv = gear_now;
		mg = max_gear_r;
		if (mode_r[0])
			d = (gv == 0) ? 0 : DUTY_SCALE / 2;
		else if (mg == 0)
			d = 0;
		else begin
			d = gv * DUTY_SCALE / mg;
			if (d >= DUTY_SCALE - 1)
				d = DUTY_SCALE - 1;
		end

		minf = min_freq_r;
		maxf = max_freq_r;
		if (!mode_r[0])
			f = maxf;
		else if (mg == 0)
			f = minf;
		else begin
			diff = maxf - minf;
			mag = (diff < 0) ? -diff : diff;
			q = gv * mag / mg;
			f = (diff < 0) ? minf - q : minf + q;
		end

		r.gear_level = gear_now;
		r.pwm_duty = 8'(d);
		r.pwm_frequency = 16'(f);
		r.fan_on = fan_now;
		r.swing_on = swing_now;
		r.backlight_on = (sleep_left != 16'd0);
		return r;
	endfunction

	function automatic script_row_t item_row(input op_t op, input logic signed [7:0] sample);
		script_row_t row;
		row = '0;
		row.op = op;
		row.sample = sample;
		return row;
	endfunction

	function automatic script_row_t checked_row(input op_t op, input fan_status_t fixed);
		script_row_t row;
		row = '0;
		row.op = op;
		row.has_fixed = 1'b1;
		row.fixed = fixed;
		return row;
	endfunction

	function automatic script_row_t write_row(input logic [2:0] index, input logic [15:0] value);
		script_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_index = index;
		row.reg_value = value;
		return row;
	endfunction

	task automatic write_register(input logic [2:0] index, input logic [15:0] value);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (index)
			REG_MODE:      mode_r = value[1:0];
			REG_MAX_GEAR:  max_gear_r = value[7:0];
			REG_MIN_FREQ:  min_freq_r = value;
			REG_MAX_FREQ:  max_freq_r = value;
			REG_LOW_TEMP:  low_r = value[7:0];
			REG_HIGH_TEMP: high_r = value[7:0];
			REG_SLEEP:     sleep_r = value;
			REG_POWER_OFF: power_off_r = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_results_drained();
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_request(input op_t op, input logic signed [7:0] sample,
			input logic has_fixed, input fan_status_t fixed);
		int gap;
		fan_status_t predicted;
		gap = calm_source ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		temperature_sample <= sample;
		do
			@(posedge clk);
		while (in_stall);
		predicted = step_controller(op, sample);
		expected_status.push_back(has_fixed ? fixed : predicted);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			if (error_count <= 200)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// result sink, with one long hold-off to back up the request side
	initial begin
		int hold;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			hold = calm_sink ? 0 : $urandom_range(0, 6);
			if (taken == 700)
				hold = 200;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		fan_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				error_count++;
				if (error_count <= 200)
					$display("%0t: result with nothing expected, gear_level %0d",
						$time, gear_level);
			end else begin
				want = expected_status.pop_front();
				check_field("gear_level", want.gear_level, gear_level);
				check_field("pwm_duty", want.pwm_duty, pwm_duty);
				check_field("pwm_frequency", want.pwm_frequency, pwm_frequency);
				check_field("fan_on", want.fan_on, fan_on);
				check_field("swing_on", want.swing_on, swing_on);
				check_field("backlight_on", want.backlight_on, backlight_on);
				check_field("gear_notice", want.gear_notice, gear_notice);
				check_field("power_notice", want.power_notice, power_notice);
				check_field("swing_notice", want.swing_notice, swing_notice);
				check_field("sleep_notice", want.sleep_notice, sleep_notice);
				check_field("wake_notice", want.wake_notice, wake_notice);
			end
		end
	end

	initial begin
		int phase, n, pick, t, lo, hi, span;
		op_t op;
		logic signed [7:0] sample;

		mode_r = MODE_RESET;
		max_gear_r = MAX_GEAR_RESET;
		min_freq_r = MIN_FREQ_RESET;
		max_freq_r = MAX_FREQ_RESET;
		low_r = LOW_TEMP_RESET;
		high_r = HIGH_TEMP_RESET;
		sleep_r = SLEEP_RESET;
		power_off_r = POWER_OFF_RESET;
		gear_now = '0;
		temp_now = '0;
		fan_now = 1'b0;
		swing_now = 1'b0;
		sleep_left = SLEEP_RESET;
		power_left = POWER_OFF_RESET;

		// reset settings first, then extremes and corner cases
		script.push_back(checked_row(OP_GEAR_UP, '{8'd1, 8'd25, 16'd25000,
			1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
		script.push_back(checked_row(OP_GEAR_DOWN, '{8'd0, 8'd0, 16'd25000,
			1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
		script.push_back(checked_row(OP_GEAR_DOWN, '{8'd0, 8'd0, 16'd25000,
			1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
		script.push_back(item_row(OP_ENCODER, 8'sd0));
		script.push_back(item_row(OP_FAN, 8'sd0));
		script.push_back(item_row(OP_SWING, 8'sd0));
		script.push_back(item_row(OP_TEMP, 8'sd127));
		script.push_back(item_row(OP_TEMP, 8'sd127));
		script.push_back(item_row(OP_SPEED, 8'sd0));
		script.push_back(write_row(REG_MODE, 16'd3));
		script.push_back(write_row(REG_MAX_GEAR, 16'd255));
		script.push_back(write_row(REG_MIN_FREQ, 16'hffff));
		script.push_back(write_row(REG_MAX_FREQ, 16'd0));
		script.push_back(write_row(REG_LOW_TEMP, 16'h0080));
		script.push_back(write_row(REG_HIGH_TEMP, 16'h007f));
		script.push_back(write_row(REG_SLEEP, 16'd1));
		script.push_back(write_row(REG_POWER_OFF, 16'd2));
		script.push_back(checked_row(OP_SPEED, '{8'd255, 8'd128, 16'd0,
			1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
		script.push_back(item_row(OP_TEMP, 8'sd0));
		script.push_back(item_row(OP_SPEED, 8'sd0));
		script.push_back(item_row(OP_FAN, 8'sd0));
		script.push_back(item_row(OP_SECOND, 8'sd0));
		script.push_back(item_row(OP_FAN, 8'sd0));
		script.push_back(item_row(OP_SECOND, 8'sd0));
		script.push_back(item_row(OP_SECOND, 8'sd0));
		script.push_back(write_row(REG_MAX_GEAR, 16'd3));
		script.push_back(item_row(OP_ENCODER, -8'sd1));
		script.push_back(write_row(REG_MAX_GEAR, 16'd0));
		script.push_back(write_row(REG_SLEEP, 16'd0));
		script.push_back(write_row(REG_MODE, 16'd0));
		script.push_back(item_row(OP_GEAR_UP, 8'sd0));
		script.push_back(item_row(OP_ENCODER, 8'sd0));
		script.push_back(item_row(OP_ENCODER, 8'sd0));
		script.push_back(write_row(REG_MODE, 16'd1));
		script.push_back(item_row(OP_SECOND, 8'sd0));
		script.push_back(item_row(OP_TEMP, -8'sd128));
		script.push_back(write_row(REG_LOW_TEMP, 16'h007f));
		script.push_back(write_row(REG_HIGH_TEMP, 16'h0080));
		script.push_back(write_row(REG_MODE, 16'd3));
		script.push_back(write_row(REG_MAX_GEAR, 16'd255));
		script.push_back(item_row(OP_FAN, 8'sd0));
		script.push_back(item_row(OP_SPEED, 8'sd0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].is_write) begin
				in_valid <= 1'b0;
				wait_results_drained();
				write_register(script[k].reg_index, script[k].reg_value);
			end else begin
				send_request(script[k].op, script[k].sample, script[k].has_fixed,
					script[k].fixed);
			end
		end

		for (phase = 0; phase < 6; phase++) begin
			in_valid <= 1'b0;
			wait_results_drained();
			calm_source = (phase == 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
			calm_sink = (phase == 1) ? 1'b1 : ($urandom_range(0, 3) == 0);

			write_register(REG_MODE, (phase == 3) ? 16'($urandom_range(0, 3)) :
				16'(2 + $urandom_range(0, 1)));
			case (phase)
				0: write_register(REG_MAX_GEAR, 16'd255);
				1: write_register(REG_MAX_GEAR, 16'd1);
				2: write_register(REG_MAX_GEAR, 16'd0);
				default: write_register(REG_MAX_GEAR, 16'($urandom_range(1, 255)));
			endcase
			write_register(REG_MIN_FREQ, (phase == 0) ? 16'd0 :
				(phase == 1) ? 16'hffff : 16'($urandom));
			write_register(REG_MAX_FREQ, (phase == 0) ? 16'hffff :
				(phase == 1) ? 16'd0 : 16'($urandom));
			lo = (phase == 0) ? -128 : int'($urandom_range(0, 255)) - 128;
			if (phase == 0)
				hi = 127;
			else if (phase == 3)
				hi = lo;
			else if (phase == 5)
				hi = int'($urandom_range(0, 255)) - 128;
			else begin
				hi = lo + int'($urandom_range(1, 40));
				if (hi > 127)
					hi = 127;
			end
			write_register(REG_LOW_TEMP, 16'(lo) & 16'h00ff);
			write_register(REG_HIGH_TEMP, 16'(hi) & 16'h00ff);
			write_register(REG_SLEEP, (phase == 0) ? 16'hffff :
				16'($urandom_range(0, 8)));
			write_register(REG_POWER_OFF, (phase == 0) ? 16'hffff :
				(phase == 2) ? 16'd0 : 16'($urandom_range(1, 8)));

			for (n = 0; n < 250; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					op = OP_GEAR_UP;
				else if (pick < 22)
					op = OP_GEAR_DOWN;
				else if (pick < 30)
					op = OP_ENCODER;
				else if (pick < 40)
					op = OP_FAN;
				else if (pick < 46)
					op = OP_SWING;
				else if (pick < 66)
					op = OP_TEMP;
				else if (pick < 82)
					op = OP_SECOND;
				else
					op = OP_SPEED;

				// half the samples land around the auto mapping window
				if ($urandom_range(0, 1) == 0) begin
					sample = 8'($urandom);
				end else begin
					lo = low_r;
					hi = high_r;
					if (hi < lo) begin
						span = lo;
						lo = hi;
						hi = span;
					end
					t = lo - 2 + int'($urandom_range(0, hi - lo + 4));
					if (t < -128)
						t = -128;
					if (t > 127)
						t = 127;
					sample = 8'(t);
				end
				send_request(op, sample, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		wait_results_drained();
		repeat (70) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_divider.sv
hw/rtl/fsc_datapath.sv
hw/rtl/fsc_ctrl.sv
hw/rtl/fan_speed_controller.sv
verif/fan_speed_controller_tb.sv
